FILE: design/gha_pkg.sv
package gha_pkg;

  localparam int unsigned BLOCK_W   = 128;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned NUM_STEPS = BLOCK_W / DIGIT_W;
  localparam int unsigned STEP_W    = $clog2(NUM_STEPS);

  localparam logic [BLOCK_W-1:0] GF_REDUCE = {8'he1, 120'd0};

  localparam logic CMD_ABSORB  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic REG_KEY_HI = 1'b0;
  localparam logic REG_KEY_LO = 1'b1;

  typedef struct packed {
    logic load;    // start multiply: X = Y ^ masked block, V = H, R = 0
    logic clear;   // Y = 0
    logic step;    // one nibble of the multiply
    logic commit;  // last nibble, Y = R
  } dp_cmd_t;

endpackage

FILE: design/gha_ctrl.sv
module gha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [4:0]         byte_count,
  output logic               out_valid,
  input  logic               out_stall,
  output gha_pkg::dp_cmd_t   dp_cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_DONE
  } state_t;

  state_t                     state;
  logic [gha_pkg::STEP_W-1:0] cnt;
  logic                       in_xfer;
  logic                       do_mult;
  logic                       last_step;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign in_xfer   = in_valid && !in_stall;
  assign do_mult   = (cmd == gha_pkg::CMD_ABSORB) && (byte_count != 5'd0);
  assign last_step = (cnt == gha_pkg::STEP_W'(gha_pkg::NUM_STEPS - 1));

  always_comb begin
    dp_cmd.load   = in_xfer && do_mult;
    dp_cmd.clear  = in_xfer && (cmd == gha_pkg::CMD_RESTART);
    dp_cmd.step   = (state == ST_MULT);
    dp_cmd.commit = (state == ST_MULT) && last_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            cnt   <= '0;
            state <= do_mult ? ST_MULT : ST_DONE;
          end
        end
        ST_MULT: begin
          cnt <= cnt + 1'b1;
          if (last_step) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/gha_dpath.sv
module gha_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [gha_pkg::WORD_W-1:0]  cfg_data,
  input  logic [gha_pkg::WORD_W-1:0]  data_hi,
  input  logic [gha_pkg::WORD_W-1:0]  data_lo,
  input  logic [4:0]                  byte_count,
  input  gha_pkg::dp_cmd_t            dp_cmd,
  output logic [gha_pkg::WORD_W-1:0]  hash_hi,
  output logic [gha_pkg::WORD_W-1:0]  hash_lo
);

  localparam int unsigned BW = gha_pkg::BLOCK_W;

  logic [gha_pkg::WORD_W-1:0] key_hi;
  logic [gha_pkg::WORD_W-1:0] key_lo;
  logic [BW-1:0]              acc;
  logic [BW-1:0]              x;
  logic [BW-1:0]              v;
  logic [BW-1:0]              r;
  logic [BW-1:0]              v_next;
  logic [BW-1:0]              r_next;
  logic [BW-1:0]              byte_mask;
  logic [4:0]                 n_sat;

  // Keep leading bytes only; counts above sixteen use the whole block.
  assign n_sat = (byte_count > 5'd16) ? 5'd16 : byte_count;

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      byte_mask[BW-1-8*b -: 8] = (5'(b) < n_sat) ? 8'hff : 8'h00;
    end
  end

  // Four bit-serial steps, most significant bit of X first.
  always_comb begin
    logic [BW-1:0] vt;
    logic [BW-1:0] rt;
    vt = v;
    rt = r;
    for (int j = 0; j < gha_pkg::DIGIT_W; j++) begin
      if (x[BW-1-j]) begin
        rt = rt ^ vt;
      end
      vt = vt[0] ? ((vt >> 1) ^ gha_pkg::GF_REDUCE) : (vt >> 1);
    end
    v_next = vt;
    r_next = rt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
    end else if (cfg_we) begin
      if (cfg_index == gha_pkg::REG_KEY_HI) begin
        key_hi <= cfg_data;
      end else begin
        key_lo <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (dp_cmd.clear) begin
      acc <= '0;
    end else if (dp_cmd.commit) begin
      acc <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      x <= acc ^ ({data_hi, data_lo} & byte_mask);
      v <= {key_hi, key_lo};
      r <= '0;
    end else if (dp_cmd.step) begin
      x <= x << gha_pkg::DIGIT_W;
      v <= v_next;
      r <= r_next;
    end
  end

  assign hash_hi = acc[BW-1 -: gha_pkg::WORD_W];
  assign hash_lo = acc[gha_pkg::WORD_W-1:0];

endmodule

FILE: design/ghash_accumulator.sv
// GHASH accumulator, Y = (Y ^ block) * H in GF(2^128), one nibble of X per cycle.
// Absorb: result offered once the multiply has stepped through all nibbles of X.
// Restart or zero byte count: result offered in the cycle after the input transfer.
// Next input accepted the cycle after the result transfer, so blocks do not overlap.
// Synchronous reset clears the accumulator and both key words.
module ghash_accumulator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [gha_pkg::WORD_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [gha_pkg::WORD_W-1:0]  data_hi,
  input  logic [gha_pkg::WORD_W-1:0]  data_lo,
  input  logic [4:0]                  byte_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gha_pkg::WORD_W-1:0]  hash_hi,
  output logic [gha_pkg::WORD_W-1:0]  hash_lo
);

  gha_pkg::dp_cmd_t dp_cmd;

  gha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .byte_count (byte_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dp_cmd     (dp_cmd)
  );

  gha_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data_hi    (data_hi),
    .data_lo    (data_lo),
    .byte_count (byte_count),
    .dp_cmd     (dp_cmd),
    .hash_hi    (hash_hi),
    .hash_lo    (hash_lo)
  );

endmodule
